// ===== hdl/ecr_pkg.sv =====
// Shared types and constants for the effect compartment Hill response unit.
package ecr_pkg;

   // configuration port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_IDX_W-1:0] CSR_RATE_IDX  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HILL_IDX  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LOGQ_IDX  = 2'd2;
   // unmapped index, writes to it are dropped
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_IDX = 2'd3;

   // register reset values
   localparam logic [31:0] RATE_RESET = 32'd16777216;
   localparam logic [23:0] HILL_RESET = 24'd65536;
   localparam logic [23:0] LOGQ_RESET = 24'd0;

   // log2(10) in Q.24
   localparam logic [25:0] LOG2_10_Q24 = 26'd55732705;

   // step counts of the iterative phases
   localparam int LOG_STEPS = 16;
   localparam int DIV_STEPS = 17;
   localparam int CNT_W     = 5;

   // datapath operations
   typedef enum logic [4:0] {
      OP_NOP,
      OP_LOAD,
      OP_EUL_P,
      OP_EUL_LO,
      OP_EUL_HI,
      OP_EUL_UPD,
      OP_LOG_INIT,
      OP_LOG_SQ,
      OP_LOG_FIN,
      OP_A_MUL,
      OP_Z_MUL,
      OP_Z_CHK,
      OP_TAB_A,
      OP_TAB_B,
      OP_I_MUL,
      OP_EXP,
      OP_DIV,
      OP_OUT
   } ecr_op_type;

   typedef struct packed {
      ecr_op_type op;
      logic       first;
   } ecr_cmd_type;

   typedef struct packed {
      logic ce_zero;
      logic z_over;
      logic z_under;
   } ecr_status_type;

endpackage

// ===== hdl/ecr_ifaces.sv =====
// Request and response channel interfaces.
interface ecr_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] sample_time;
   logic [31:0] plasma_conc;
   logic        series_start;

   modport source (output valid, output sample_time, output plasma_conc,
                   output series_start, input ready);
   modport sink (input valid, input sample_time, input plasma_conc,
                 input series_start, output ready);
endinterface

interface ecr_rsp_if;
   logic        valid;
   logic        ready;
   logic [16:0] effect_fraction;
   logic [31:0] effect_conc;

   modport source (output valid, output effect_fraction, output effect_conc,
                   input ready);
   modport sink (input valid, input effect_fraction, input effect_conc,
                 output ready);
endinterface

// ===== hdl/ecr_datapath.sv =====
// Datapath: state, configuration, shared multiplier, log/exp table and divider.
module ecr_datapath import ecr_pkg::*; #(
   parameter int TABLE_ADDR_BITS = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  ecr_cmd_type           cmd,
   output ecr_status_type        status,
   input  logic [31:0]           in_time,
   input  logic [31:0]           in_plasma,
   input  logic                  in_start,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output logic [16:0]           out_fraction,
   output logic [31:0]           out_conc
);

   localparam int TAB_N = 1 << TABLE_ADDR_BITS;
   localparam int SH    = 16 - TABLE_ADDR_BITS;
   localparam int IDX_W = TABLE_ADDR_BITS + 1;
   localparam logic signed [36:0] Z_LIMIT = 37'sd2097152;

   typedef logic [31:0] tab_type [0:TAB_N];

   function automatic logic [63:0] isqrt64(input logic [63:0] xin);
      logic [63:0] x;
      logic [63:0] r;
      logic [63:0] b;
      x = xin;
      r = 64'd0;
      b = 64'd1 << 62;
      while (b > x) b = b >> 2;
      while (b != 64'd0) begin
         if (x >= r + b) begin
            x = x - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   // 2^(i/TAB_N) in Q1.30 from repeated square roots of two
   function automatic tab_type build_tab();
      logic [63:0] root [0:TABLE_ADDR_BITS];
      logic [63:0] p;
      tab_type     t;
      root[0] = 64'd1 << 31;
      for (int k = 1; k <= TABLE_ADDR_BITS; k++)
         root[k] = isqrt64(root[k-1] << 30);
      for (int i = 0; i < TAB_N; i++) begin
         p = 64'd1 << 30;
         for (int j = 0; j < TABLE_ADDR_BITS; j++)
            if (i[j])
               p = (p * root[TABLE_ADDR_BITS-j] + (64'd1 << 29)) >> 30;
         t[i] = p[31:0];
      end
      t[TAB_N] = 32'h8000_0000;
      return t;
   endfunction

   localparam tab_type EXP_TAB = build_tab();

   // registers
   logic [31:0]        rate_ff, hill_ff_w;
   logic [23:0]        hill_ff;
   logic signed [23:0] logq_ff;
   logic [31:0]        last_time_ff, last_plasma_ff, site_ff;
   logic [31:0]        time_ff, plasma_ff;
   logic               start_ff;
   logic signed [65:0] prod_ff;
   logic [63:0]        p_ff, lo_ff;
   logic [31:0]        x_ff;
   logic [4:0]         lead_ff;
   logic [15:0]        frac_ff;
   logic signed [36:0] z_ff;
   logic [31:0]        ea_ff, tab_q_ff;
   logic [63:0]        rem_ff;
   logic [78:0]        dsh_ff;
   logic [16:0]        quot_ff;
   logic [16:0]        frac_out_ff;
   logic [31:0]        conc_out_ff;

   // combinational
   logic signed [32:0] dt, ddf, neg_dt, neg_ddf;
   logic [31:0]        adt, adf;
   logic               step_neg;
   logic [64:0]        sum65;
   logic [56:0]        delta_raw;
   logic [33:0]        delta;
   logic signed [35:0] ce_sum;
   logic [31:0]        ce_in;
   logic [4:0]         lead;
   logic [34:0]        sq;
   logic               sq_bit;
   logic [31:0]        x_next, x_op;
   logic signed [20:0] log_val;
   logic signed [27:0] d_val;
   logic signed [5:0]  zi, neg_zi;
   logic [15:0]        zf;
   logic [IDX_W-1:0]   tab_addr;
   logic [31:0]        e_val;
   logic [62:0]        pw, den;
   logic               div_ge;
   logic signed [32:0] mul_a, mul_b;
   logic signed [65:0] prod_in;

   assign hill_ff_w = {8'd0, hill_ff};

   // Euler step magnitudes and sign
   always_comb begin
      dt       = signed'({1'b0, time_ff}) - signed'({1'b0, last_time_ff});
      ddf      = signed'({1'b0, last_plasma_ff}) - signed'({1'b0, site_ff});
      neg_dt   = -dt;
      neg_ddf  = -ddf;
      adt      = dt[32] ? neg_dt[31:0] : dt[31:0];
      adf      = ddf[32] ? neg_ddf[31:0] : ddf[31:0];
      step_neg = dt[32] ^ ddf[32];
   end

   // delta = |dt|*ke0*|diff| >> 40, capped, then applied with saturation
   always_comb begin
      sum65     = {1'b0, prod_ff[63:0]} + {33'd0, lo_ff[63:32]};
      delta_raw = sum65[64:8];
      delta     = (delta_raw > 57'h2_0000_0000) ? 34'h2_0000_0000 : delta_raw[33:0];
      ce_sum    = step_neg ? (signed'({4'd0, site_ff}) - signed'({2'd0, delta}))
                           : (signed'({4'd0, site_ff}) + signed'({2'd0, delta}));
      if (ce_sum < 0)
         ce_in = 32'd0;
      else if (ce_sum > 36'sh0_FFFF_FFFF)
         ce_in = 32'hFFFF_FFFF;
      else
         ce_in = ce_sum[31:0];
   end

   // leading one of Ce
   always_comb begin
      lead = 5'd0;
      for (int i = 0; i < 32; i++)
         if (site_ff[i]) lead = 5'(i);
   end

   // squaring step of the log fraction
   always_comb begin
      sq      = prod_ff[65:31];
      sq_bit  = sq[32];
      x_next  = sq_bit ? sq[32:1] : sq[31:0];
      x_op    = cmd.first ? x_ff : x_next;
      log_val = signed'({~lead_ff[4], lead_ff[3:0], frac_ff});
      d_val   = 28'(signed'(prod_ff[49:24])) - 28'(log_val);
   end

   // exponent split, table address and 2^z; a right shift by 32 clears the value
   always_comb begin
      zi       = z_ff[21:16];
      neg_zi   = -zi;
      zf       = z_ff[15:0];
      tab_addr = (cmd.op == OP_TAB_B) ? (IDX_W'(zf[15:SH]) + IDX_W'(1)) : IDX_W'(zf[15:SH]);
      e_val    = ea_ff + prod_ff[SH+31:SH];
      pw       = zi[5] ? ({31'd0, e_val} >> $unsigned(neg_zi))
                       : ({31'd0, e_val} << zi[4:0]);
      den      = 63'(64'd1 << 30) + pw;
      div_ge   = {15'd0, rem_ff} >= dsh_ff;
   end

   // shared multiplier operand select
   always_comb begin
      mul_a = 33'sd0;
      mul_b = 33'sd0;
      unique case (cmd.op)
         OP_EUL_P: begin
            mul_a = signed'({1'b0, adt});
            mul_b = signed'({1'b0, rate_ff});
         end
         OP_EUL_LO: begin
            mul_a = signed'({1'b0, prod_ff[31:0]});
            mul_b = signed'({1'b0, adf});
         end
         OP_EUL_HI: begin
            mul_a = signed'({1'b0, p_ff[63:32]});
            mul_b = signed'({1'b0, adf});
         end
         OP_LOG_SQ: begin
            mul_a = signed'({1'b0, x_op});
            mul_b = signed'({1'b0, x_op});
         end
         OP_A_MUL: begin
            mul_a = 33'(logq_ff);
            mul_b = signed'({7'd0, LOG2_10_Q24});
         end
         OP_Z_MUL: begin
            mul_a = signed'({1'b0, hill_ff_w});
            mul_b = 33'(d_val);
         end
         OP_I_MUL: begin
            mul_a = signed'({1'b0, tab_q_ff - ea_ff});
            mul_b = signed'(33'(zf[SH-1:0]));
         end
         default: begin
            mul_a = 33'sd0;
            mul_b = 33'sd0;
         end
      endcase
      prod_in = mul_a * mul_b;
   end

   // configuration and series state
   always_ff @(posedge clock) begin
      if (reset) begin
         rate_ff        <= RATE_RESET;
         hill_ff        <= HILL_RESET;
         logq_ff        <= signed'(LOGQ_RESET);
         last_time_ff   <= 32'd0;
         last_plasma_ff <= 32'd0;
         site_ff        <= 32'd0;
      end else begin
         if (csr_we) begin
            if (csr_index == CSR_RATE_IDX) rate_ff <= csr_wdata;
            if (csr_index == CSR_HILL_IDX) hill_ff <= csr_wdata[23:0];
            if (csr_index == CSR_LOGQ_IDX) logq_ff <= signed'(csr_wdata[23:0]);
         end
         if (cmd.op == OP_EUL_UPD) begin
            site_ff        <= start_ff ? 32'd0 : ce_in;
            last_time_ff   <= time_ff;
            last_plasma_ff <= plasma_ff;
         end
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      tab_q_ff <= EXP_TAB[tab_addr];
      unique case (cmd.op)
         OP_LOAD: begin
            time_ff   <= in_time;
            plasma_ff <= in_plasma;
            start_ff  <= in_start;
         end
         OP_EUL_P:   prod_ff <= prod_in;
         OP_EUL_LO: begin
            p_ff    <= prod_ff[63:0];
            prod_ff <= prod_in;
         end
         OP_EUL_HI: begin
            lo_ff   <= prod_ff[63:0];
            prod_ff <= prod_in;
         end
         OP_LOG_INIT: begin
            lead_ff <= lead;
            x_ff    <= site_ff << (~lead);
            frac_ff <= 16'd0;
         end
         OP_LOG_SQ: begin
            prod_ff <= prod_in;
            x_ff    <= x_op;
            if (!cmd.first) frac_ff <= {frac_ff[14:0], sq_bit};
         end
         OP_LOG_FIN: frac_ff <= {frac_ff[14:0], sq_bit};
         OP_A_MUL:   prod_ff <= prod_in;
         OP_Z_MUL:   prod_ff <= prod_in;
         OP_Z_CHK:   z_ff    <= prod_ff[52:16];
         OP_TAB_B:   ea_ff   <= tab_q_ff;
         OP_I_MUL:   prod_ff <= prod_in;
         OP_EXP: begin
            rem_ff  <= (64'd1 << 46) + {1'b0, den[62:1]};
            dsh_ff  <= {den, 16'd0};
            quot_ff <= 17'd0;
         end
         OP_DIV: begin
            if (div_ge) rem_ff <= rem_ff - dsh_ff[63:0];
            quot_ff <= {quot_ff[15:0], div_ge};
            dsh_ff  <= dsh_ff >> 1;
         end
         OP_OUT: begin
            conc_out_ff <= site_ff;
            if (status.ce_zero || status.z_over)
               frac_out_ff <= 17'd0;
            else if (status.z_under)
               frac_out_ff <= 17'h1_0000;
            else
               frac_out_ff <= quot_ff;
         end
         default: ;
      endcase
   end

   assign status.ce_zero = (site_ff == 32'd0);
   assign status.z_over  = (z_ff >= Z_LIMIT);
   assign status.z_under = (z_ff <= -Z_LIMIT);

   assign out_fraction = frac_out_ff;
   assign out_conc     = conc_out_ff;

endmodule

// ===== hdl/ecr_controller.sv =====
// Controller: sequences one sample through the datapath and runs both handshakes.
module ecr_controller import ecr_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   output logic           rsp_valid,
   input  logic           rsp_ready,
   input  ecr_status_type status,
   output ecr_cmd_type    cmd
);

   typedef enum logic [4:0] {
      S_IDLE, S_EP, S_ELO, S_EHI, S_EUPD, S_LINIT, S_LSQ, S_LFIN,
      S_AMUL, S_ZMUL, S_ZCHK, S_TA, S_TB, S_IMUL, S_EXP, S_DIV, S_FIN
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // next state and datapath command
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd.op       = OP_NOP;
      cmd.first    = (cnt_ff == '0);
      unique case (state_ff)
         S_IDLE: if (req_valid) begin
            cmd.op   = OP_LOAD;
            state_in = S_EP;
         end
         S_EP:   begin cmd.op = OP_EUL_P;   state_in = S_ELO;   end
         S_ELO:  begin cmd.op = OP_EUL_LO;  state_in = S_EHI;   end
         S_EHI:  begin cmd.op = OP_EUL_HI;  state_in = S_EUPD;  end
         S_EUPD: begin cmd.op = OP_EUL_UPD; state_in = S_LINIT; end
         S_LINIT: begin
            cmd.op   = OP_LOG_INIT;
            cnt_in   = '0;
            state_in = status.ce_zero ? S_FIN : S_LSQ;
         end
         S_LSQ: begin
            cmd.op = OP_LOG_SQ;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(LOG_STEPS - 1)) state_in = S_LFIN;
         end
         S_LFIN: begin cmd.op = OP_LOG_FIN; state_in = S_AMUL; end
         S_AMUL: begin cmd.op = OP_A_MUL;   state_in = S_ZMUL; end
         S_ZMUL: begin cmd.op = OP_Z_MUL;   state_in = S_ZCHK; end
         S_ZCHK: begin cmd.op = OP_Z_CHK;   state_in = S_TA;   end
         S_TA: begin
            if (status.z_over || status.z_under) begin
               state_in = S_FIN;
            end else begin
               cmd.op   = OP_TAB_A;
               state_in = S_TB;
            end
         end
         S_TB:   begin cmd.op = OP_TAB_B; state_in = S_IMUL; end
         S_IMUL: begin cmd.op = OP_I_MUL; state_in = S_EXP;  end
         S_EXP: begin
            cmd.op   = OP_EXP;
            cnt_in   = '0;
            state_in = S_DIV;
         end
         S_DIV: begin
            cmd.op = OP_DIV;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(DIV_STEPS - 1)) state_in = S_FIN;
         end
         S_FIN: if (out_free) begin
            cmd.op       = OP_OUT;
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

`ifndef SYNTHESIS
   // a beat taken in always starts the Euler step next
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == S_EP))
      else $error("accepted beat did not start processing");

   // a pending result is never overwritten
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FIN && rsp_valid_ff && !rsp_ready) |=> (state_ff == S_FIN))
      else $error("result overwritten while waiting");

   // divider step counter never runs past its bound
   a_div_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV) |-> (cnt_ff <= CNT_W'(DIV_STEPS - 1)))
      else $error("divider step count overrun");

   // squaring loop stays in range
   a_log_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_LSQ) |-> (cnt_ff <= CNT_W'(LOG_STEPS - 1)))
      else $error("log step count overrun");
`endif

endmodule

// ===== hdl/effect_compartment_hill_response_unit.sv =====
// Top level: effect compartment Euler step and Hill fraction, one sample at a time.
// Each beat runs the Euler step, the 16 squaring steps of log2 on the shared
// multiplier, the Hill exponent and the 17-step restoring divider; it skips to the
// result when Ce is zero (series start) or when |z| reaches 32. A new beat is taken
// only once the last result is in the output register. A finished result waits there.
// Reset (synchronous, active high) restores the register defaults and clears state.
module effect_compartment_hill_response_unit import ecr_pkg::*; #(
   parameter int TABLE_ADDR_BITS = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   ecr_req_if.sink               req_if,
   ecr_rsp_if.source             rsp_if,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   ecr_cmd_type    cmd;
   ecr_status_type status;

   // sequencing
   ecr_controller u_ctl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // arithmetic and state
   ecr_datapath #(.TABLE_ADDR_BITS(TABLE_ADDR_BITS)) u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .in_time      (req_if.sample_time),
      .in_plasma    (req_if.plasma_conc),
      .in_start     (req_if.series_start),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .out_fraction (rsp_if.effect_fraction),
      .out_conc     (rsp_if.effect_conc)
   );

endmodule

// ===== dv/ecr_hill_checker.sv =====
// Beat monitor, Hill response predictor and result scoreboard.
`timescale 1ns / 100ps
module ecr_hill_checker import ecr_pkg::*; #(
   parameter int TABLE_ADDR_BITS = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   ecr_req_if                    req,
   ecr_rsp_if                    rsp,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int                    fail_count,
   output int                    pending
);
   localparam int TAB_N = 1 << TABLE_ADDR_BITS;

   typedef struct {
      logic [16:0] fraction;
      logic [31:0] conc;
   } effect_beat_type;

   effect_beat_type   effect_queue[$];
   longint unsigned   pow2_frac_tab[0:TAB_N];

   // predictor copy of registers and state
   logic [31:0] ke0;
   logic [23:0] hill_n;
   logic [23:0] log_ec50;
   logic [31:0] prev_time;
   logic [31:0] prev_plasma;
   logic [31:0] site_ce;

   assign pending = effect_queue.size();

   function automatic longint unsigned int_sqrt(longint unsigned x);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > x) b >>= 2;
      while (b != 0) begin
         if (x >= r + b) begin
            x -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   // 2^(i/TAB_N) in Q1.30 from repeated square roots of two
   initial begin : build_pow2
      longint unsigned roots[0:TABLE_ADDR_BITS];
      longint unsigned p;
      roots[0] = 64'd1 << 31;
      for (int k = 1; k <= TABLE_ADDR_BITS; k++) roots[k] = int_sqrt(roots[k-1] << 30);
      for (int i = 0; i < TAB_N; i++) begin
         p = 64'd1 << 30;
         for (int j = 0; j < TABLE_ADDR_BITS; j++)
            if ((i >> j) & 1) p = (p * roots[TABLE_ADDR_BITS-j] + (64'd1 << 29)) >> 30;
         pow2_frac_tab[i] = p;
      end
      pow2_frac_tab[TAB_N] = 64'd1 << 31;
   end

   // log2 of a nonzero Q16.16 value, signed Q.16
   function automatic longint log2_conc(logic [31:0] v);
      int              p;
      longint unsigned x;
      longint          frac;
      p = 31;
      while (!v[p]) p--;
      x = ({32'd0, v} << (31 - p)) & 64'hFFFF_FFFF;
      frac = 0;
      for (int i = 0; i < 16; i++) begin
         x = (x * x) >> 31;
         frac = frac << 1;
         if (x >= (64'd1 << 32)) begin
            frac |= 1;
            x >>= 1;
         end
      end
      return longint'(p - 16) * 65536 + frac;
   endfunction

   function automatic logic [16:0] hill_of(logic [31:0] ce);
      longint          q, a, d, z, zi, f;
      longint unsigned e, lo_v, hi_v, pw, den;
      int              sh, idx;
      if (ce == 0) return '0;
      q = longint'(signed'(log_ec50));
      a = (q * longint'(LOG2_10_Q24)) >>> 24;
      d = a - log2_conc(ce);
      z = (longint'(hill_n) * d) >>> 16;
      if (z >= 32 * 65536) return '0;
      if (z <= -32 * 65536) return 17'd65536;
      zi = z >>> 16;
      f = z - zi * 65536;
      sh = 16 - TABLE_ADDR_BITS;
      idx = int'(f >> sh);
      lo_v = pow2_frac_tab[idx];
      hi_v = pow2_frac_tab[idx+1];
      e = lo_v + (((hi_v - lo_v) * longint'(f & ((1 << sh) - 1))) >> sh);
      pw = (zi >= 0) ? (e << zi) : (e >> (-zi));
      den = (64'd1 << 30) + pw;
      return 17'(((64'd1 << 46) + den / 2) / den);
   endfunction

   // one Euler step (or series restart), then the fraction
   function automatic effect_beat_type predict_sample(logic [31:0] t, logic [31:0] cp,
                                                      logic start);
      effect_beat_type r;
      longint          dt, diff, ce;
      longint unsigned adt, adf, p, lo, hi, delta;
      logic            neg;
      if (start) begin
         site_ce = '0;
      end else begin
         dt = longint'(t) - longint'(prev_time);
         diff = longint'(prev_plasma) - longint'(site_ce);
         neg = (dt < 0) != (diff < 0);
         adt = dt < 0 ? -dt : dt;
         adf = diff < 0 ? -diff : diff;
         p = adt * longint'(ke0);
         lo = (p & 64'hFFFF_FFFF) * adf;
         hi = (p >> 32) * adf;
         delta = (hi + (lo >> 32)) >> 8;
         if (delta > (64'd1 << 33)) delta = 64'd1 << 33;
         ce = longint'(site_ce) + (neg ? -longint'(delta) : longint'(delta));
         if (ce < 0) ce = 0;
         if (ce > 64'hFFFF_FFFF) ce = 64'hFFFF_FFFF;
         site_ce = ce[31:0];
      end
      prev_time = t;
      prev_plasma = cp;
      r.conc = site_ce;
      r.fraction = hill_of(site_ce);
      return r;
   endfunction

   task automatic report_mismatch(string what);
      $display("%0t mismatch: %s", $realtime, what);
      fail_count++;
   endtask

   initial fail_count = 0;

   // watch all three ports at each edge
   always @(posedge clock) begin
      effect_beat_type want;
      if (reset) begin
         ke0 = RATE_RESET;
         hill_n = HILL_RESET;
         log_ec50 = LOGQ_RESET;
         prev_time = '0;
         prev_plasma = '0;
         site_ce = '0;
         effect_queue.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_RATE_IDX: ke0 = csr_wdata;
               CSR_HILL_IDX: hill_n = csr_wdata[23:0];
               CSR_LOGQ_IDX: log_ec50 = csr_wdata[23:0];
               default: ;
            endcase
         end
         if (req.valid && req.ready)
            effect_queue.push_back(predict_sample(req.sample_time, req.plasma_conc,
                                                  req.series_start));
         if (rsp.valid && rsp.ready) begin
            if (effect_queue.size() == 0) begin
               report_mismatch("result beat with nothing expected");
            end else begin
               want = effect_queue.pop_front();
               if (rsp.effect_fraction !== want.fraction)
                  report_mismatch($sformatf("effect_fraction got %0d want %0d",
                                            rsp.effect_fraction, want.fraction));
               if (rsp.effect_conc !== want.conc)
                  report_mismatch($sformatf("effect_conc got %h want %h",
                                            rsp.effect_conc, want.conc));
            end
         end
      end
   end
endmodule

// ===== dv/tb_effect_compartment_hill_response_unit.sv =====
// Testbench top: clock, reset, sample stimulus, register phases and verdict.
`timescale 1ns / 100ps
module tb_effect_compartment_hill_response_unit;
   import ecr_pkg::*;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = CSR_RATE_IDX;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;
   int                    fail_count;
   int                    pending;
   logic                  no_gaps = 1'b0;
   logic [31:0]           now_t;

   ecr_req_if req ();
   ecr_rsp_if rsp ();

   effect_compartment_hill_response_unit DUT (
      .clock(clock), .reset(reset), .req_if(req), .rsp_if(rsp),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   ecr_hill_checker u_checker (
      .clock(clock), .reset(reset), .req(req), .rsp(rsp),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .fail_count(fail_count), .pending(pending)
   );

   always #4 clock = ~clock;

   initial begin
      req.valid = 1'b0;
      req.sample_time = '0;
      req.plasma_conc = '0;
      req.series_start = 1'b0;
      rsp.ready = 1'b0;
   end

   // result side stall pattern
   always begin
      int k;
      @(posedge clock);
      while (!reset) begin
         k = no_gaps ? 0 : $urandom_range(5);
         if (k > 0) begin
            rsp.ready <= 1'b0;
            repeat (k) @(posedge clock);
         end
         rsp.ready <= 1'b1;
         do @(posedge clock); while (!rsp.valid);
      end
   end

   task automatic send_sample(logic [31:0] t, logic [31:0] cp, logic start);
      int k;
      k = no_gaps ? 0 : $urandom_range(5);
      if (k > 0) begin
         req.valid <= 1'b0;
         repeat (k) @(posedge clock);
      end
      req.valid <= 1'b1;
      req.sample_time <= t;
      req.plasma_conc <= cp;
      req.series_start <= start;
      do @(posedge clock); while (!req.ready);
   endtask

   // drain all results, then hold the request side idle before returning
   task automatic drain;
      req.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [31:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // well-formed series with occasional restarts, back steps and raw noise
   task automatic run_series(int count);
      int          scale;
      logic [31:0] cp;
      for (int i = 0; i < count; i++) begin
         if (i % 50 == 0) no_gaps <= ($urandom_range(3) == 0);
         scale = $urandom_range(31);
         cp = $urandom() >> scale;
         case ($urandom_range(19))
            0: send_sample($urandom(), $urandom(), $urandom_range(1));
            1: begin
               now_t = $urandom();
               send_sample(now_t, cp, 1'b1);
            end
            2: begin
               now_t = now_t - $urandom_range(32'h40000);
               send_sample(now_t, cp, 1'b0);
            end
            default: begin
               now_t = now_t + $urandom_range(32'h40000);
               send_sample(now_t, cp, 1'b0);
            end
         endcase
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: default registers
      send_sample(32'h0, 32'hFFFF_FFFF, 1'b1);
      send_sample(32'h0001_0000, 32'h0, 1'b0);
      send_sample(32'h0, 32'h0, 1'b0);
      send_sample(32'hFFFF_FFFF, 32'h0001_0000, 1'b0);
      send_sample(32'h0, 32'h0001_0000, 1'b1);
      send_sample(32'h0000_8000, 32'h0000_0001, 1'b0);
      send_sample(32'h0001_0000, 32'hFFFF_FFFF, 1'b0);
      send_sample(32'h0002_0000, 32'h0000_0000, 1'b0);
      send_sample(32'h0001_0000, 32'h0005_0000, 1'b0);
      send_sample(32'hAAAA_AAAA, 32'h5555_5555, 1'b1);
      send_sample(32'h5555_5555, 32'hAAAA_AAAA, 1'b0);
      // sender holds off until everything is back
      drain();

      // directed: zero exponent, then extreme EC50 in both directions
      write_reg(CSR_HILL_IDX, 32'h0);
      write_reg(CSR_SPARE_IDX, 32'hFFFF_FFFF);
      send_sample(32'h0, 32'h0010_0000, 1'b1);
      send_sample(32'h0001_0000, 32'h0010_0000, 1'b0);
      send_sample(32'h0002_0000, 32'h0010_0000, 1'b0);
      drain();
      write_reg(CSR_HILL_IDX, 32'h00FF_FFFF);
      write_reg(CSR_LOGQ_IDX, 32'h0080_0000);
      send_sample(32'h0003_0000, 32'h0010_0000, 1'b0);
      send_sample(32'h0004_0000, 32'h0010_0000, 1'b0);
      drain();
      write_reg(CSR_LOGQ_IDX, 32'h007F_FFFF);
      send_sample(32'h0005_0000, 32'h0010_0000, 1'b0);
      send_sample(32'h0006_0000, 32'hFFFF_FFFF, 1'b0);
      drain();

      // random phases over several register settings
      now_t = '0;
      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: begin
               write_reg(CSR_RATE_IDX, RATE_RESET);
               write_reg(CSR_HILL_IDX, HILL_RESET);
               write_reg(CSR_LOGQ_IDX, 32'h0001_0000);
            end
            1: begin
               write_reg(CSR_RATE_IDX, 32'hFFFF_FFFF);
               write_reg(CSR_HILL_IDX, 32'h0004_0000);
               write_reg(CSR_LOGQ_IDX, 32'h0000_8000);
            end
            2: begin
               write_reg(CSR_RATE_IDX, 32'h0);
               write_reg(CSR_HILL_IDX, 32'h0000_4000);
            end
            3: begin
               write_reg(CSR_RATE_IDX, 32'h0020_0000);
               write_reg(CSR_HILL_IDX, 32'h0002_8000);
               write_reg(CSR_LOGQ_IDX, 32'h00FF_0000);
            end
            default: begin
               write_reg(CSR_RATE_IDX, $urandom());
               write_reg(CSR_HILL_IDX, $urandom_range(32'h0008_0000));
               write_reg(CSR_LOGQ_IDX, $urandom_range(32'h0005_0000) - 32'h0002_0000);
            end
         endcase
         run_series(270);
         no_gaps <= 1'b0;
         drain();
      end

      if (fail_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      #20ms;
      $display("[FAIL] regression broken");
      $finish;
   end
endmodule
